### rtl/core/hsvm_pkg.sv
// ----------------------------------------------------------------------------
// hsvm_pkg
// shared widths, command codes and fixed-point helpers for the huberized
// hinge svm loss and gradient unit
// ----------------------------------------------------------------------------
package hsvm_pkg;

  // feature space and row buffer
  localparam int NUM_FEATURES = 1024;
  localparam int FEAT_W       = 10;
  localparam int MAX_ROW      = 64;
  localparam int ROW_W        = 6;
  localparam int FILL_W       = 7;

  // datapath widths
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 48;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;
  localparam int NORM_W = 56;

  // command codes
  localparam logic [2:0] CMD_WRITE_WEIGHT = 3'd0;
  localparam logic [2:0] CMD_SAMPLE_ENTRY = 3'd1;
  localparam logic [2:0] CMD_READ_LOSS    = 3'd2;
  localparam logic [2:0] CMD_READ_GRAD    = 3'd3;
  localparam logic [2:0] CMD_CLEAR        = 3'd4;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

  // clamp a wide signed value to 48 bits
  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
    logic fits;
    fits = (&v[PROD_W-1:ACC_W-1]) | ~(|v[PROD_W-1:ACC_W-1]);
    if (fits) begin
      return v[ACC_W-1:0];
    end else if (v[PROD_W-1]) begin
      return ACC_MIN;
    end else begin
      return ACC_MAX;
    end
  endfunction

  // shift right by 16, round to nearest, ties away from zero
  function automatic logic signed [PROD_W-1:0] rshift16(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    r = (mag + PROD_W'(32768)) >> 16;
    return p[PROD_W-1] ? -$signed(r) : $signed(r);
  endfunction

  // shift right by 17, same rounding
  function automatic logic signed [PROD_W-1:0] rshift17(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] r;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    r = (mag + PROD_W'(65536)) >> 17;
    return p[PROD_W-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

### rtl/core/huber_svm_loss_gradient_unit.sv
// ----------------------------------------------------------------------------
// huber_svm_loss_gradient_unit
// l2-regularized huberized hinge svm objective and gradient, q16.16, built
// around one shared multiplier under a small sequencer
// ----------------------------------------------------------------------------
//
//  channel   direction  transfer carries
//  --------  ---------  -------------------------------------------------------
//  s_*       in         command, feature index/value, label, row end
//  m_*       out        objective or gradient element, kind, overflow flag
//  reg_*     in         regularization constant c, unsigned q16.16
//
//  weight write: written as accepted. sample entry: weight read, multiply and
//  margin add; the last entry of a row adds a classify step, a square on the
//  quadratic side and a read, multiply and write per buffered entry for the
//  gradient replay. loss read: read, square and add per feature, scaling by c,
//  output step. gradient read: read, scaling by c, output step. clear: sweeps
//  the gradient memory. after reset both memories are swept to zero before
//  s_tready rises. a result waiting on m_tready holds the sequencer in its
//  output step only when the next result is ready too.
//
module huber_svm_loss_gradient_unit
  import hsvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // feature_index[9:0], feature_value[41:10], label_positive[42]
  input  logic [2:0]  s_tuser,   // command[2:0]
  input  logic        s_tlast,   // row_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // result_value[47:0]
  output logic [1:0]  m_tuser,   // result_kind[0], row_overflow[1]
  input  logic        reg_weight_we,
  input  logic [31:0] reg_weight_wdata
);

  // sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_WSWEEP = 5'd1;
  localparam logic [4:0] ST_GSWEEP = 5'd2;
  localparam logic [4:0] ST_E_RD   = 5'd3;
  localparam logic [4:0] ST_E_MUL  = 5'd4;
  localparam logic [4:0] ST_E_ACC  = 5'd5;
  localparam logic [4:0] ST_F_Z    = 5'd6;
  localparam logic [4:0] ST_F_T    = 5'd7;
  localparam logic [4:0] ST_F_SQ   = 5'd8;
  localparam logic [4:0] ST_G_RD   = 5'd9;
  localparam logic [4:0] ST_G_GR   = 5'd10;
  localparam logic [4:0] ST_G_WR   = 5'd11;
  localparam logic [4:0] ST_N_RD   = 5'd12;
  localparam logic [4:0] ST_N_MUL  = 5'd13;
  localparam logic [4:0] ST_N_ACC  = 5'd14;
  localparam logic [4:0] ST_R_RD   = 5'd15;
  localparam logic [4:0] ST_R_DAT  = 5'd16;
  localparam logic [4:0] ST_SC_HI  = 5'd17;
  localparam logic [4:0] ST_SC_LO  = 5'd18;
  localparam logic [4:0] ST_SC_FIN = 5'd19;
  localparam logic [4:0] ST_PUT    = 5'd20;

  localparam logic [FEAT_W:0]   NF_LIM   = (FEAT_W+1)'(NUM_FEATURES);
  localparam logic [FEAT_W-1:0] CNT_LAST = FEAT_W'(NUM_FEATURES - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_ROW);

  logic [4:0] state;

  // input fields
  logic [2:0]              in_cmd;
  logic [FEAT_W-1:0]       in_idx;
  logic signed [VAL_W-1:0] in_val;
  logic                    in_pos;
  logic                    in_ok;
  logic                    s_fire;

  assign in_cmd = s_tuser;
  assign in_idx = s_tdata[9:0];
  assign in_val = s_tdata[41:10];
  assign in_pos = s_tdata[42];
  assign in_ok  = ({1'b0, in_idx} < NF_LIM);
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid & s_tready;

  // captured command
  logic [FEAT_W-1:0]       idx_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    pos_r;
  logic                    last_r;

  // accumulators and flags
  logic [31:0]              reg_weight;
  logic signed [ACC_W-1:0]  margin;
  logic signed [ACC_W-1:0]  loss;
  logic                     overflow_seen;
  logic [FILL_W-1:0]        fill;
  logic [FILL_W-1:0]        k;
  logic [FEAT_W-1:0]        cnt;
  logic                     hinge;
  logic [16:0]              tmag;
  logic signed [17:0]       coef;
  logic [NORM_W-1:0]        norm;
  logic signed [ACC_W-1:0]  sc_src;
  logic signed [VAL_W-1:0]  wsave;
  logic                     sc_loss;
  logic [56:0]              hi_q;
  logic signed [ACC_W-1:0]  res;
  logic                     res_kind;

  // memories
  logic signed [VAL_W-1:0] weight_mem [NUM_FEATURES];
  logic signed [ACC_W-1:0] grad_mem   [NUM_FEATURES];
  logic [FEAT_W-1:0]       idx_buf    [MAX_ROW];
  logic signed [VAL_W-1:0] val_buf    [MAX_ROW];

  logic [FEAT_W-1:0]       w_addr;
  logic                    w_we;
  logic signed [VAL_W-1:0] w_wdata;
  logic signed [VAL_W-1:0] w_rdata;
  logic [FEAT_W-1:0]       g_raddr;
  logic [FEAT_W-1:0]       g_waddr;
  logic                    g_we;
  logic signed [ACC_W-1:0] g_wdata;
  logic signed [ACC_W-1:0] g_rdata;
  logic                    b_we;
  logic [FEAT_W-1:0]       b_idx;
  logic signed [VAL_W-1:0] b_val;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  hsvm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // weight memory, one port
  always_comb begin
    case (state)
      ST_E_RD, ST_R_RD:    w_addr = idx_r;
      ST_N_RD, ST_WSWEEP:  w_addr = cnt;
      default:             w_addr = in_idx;
    endcase
    w_we    = (state == ST_WSWEEP) |
              (s_fire & (in_cmd == CMD_WRITE_WEIGHT) & in_ok);
    w_wdata = (state == ST_WSWEEP) ? '0 : in_val;
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_addr] <= w_wdata;
    end
    w_rdata <= weight_mem[w_addr];
  end

  // gradient memory, one read and one write port
  logic signed [PROD_W-1:0] g_term;
  logic signed [PROD_W-1:0] g_hinge;

  assign g_hinge = pos_r ? -PROD_W'(b_val) : PROD_W'(b_val);
  assign g_term  = hinge ? g_hinge : rshift16(prod);

  always_comb begin
    g_raddr = (state == ST_R_RD) ? idx_r : b_idx;
    g_waddr = (state == ST_G_WR) ? b_idx : cnt;
    g_we    = (state == ST_G_WR) | (state == ST_GSWEEP) | (state == ST_WSWEEP);
    g_wdata = (state == ST_G_WR) ? sat48(PROD_W'(g_rdata) + g_term) : '0;
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      grad_mem[g_waddr] <= g_wdata;
    end
    g_rdata <= grad_mem[g_raddr];
  end

  // row buffer
  assign b_we = s_fire & (in_cmd == CMD_SAMPLE_ENTRY) & in_ok & (fill < FILL_MAX);

  always_ff @(posedge clk) begin
    if (b_we) begin
      idx_buf[fill[ROW_W-1:0]] <= in_idx;
      val_buf[fill[ROW_W-1:0]] <= in_val;
    end
    b_idx <= idx_buf[k[ROW_W-1:0]];
    b_val <= val_buf[k[ROW_W-1:0]];
  end

  // scaling by c, split into two 24-bit halves of the magnitude
  logic [ACC_W-1:0] sc_mag;
  assign sc_mag = sc_src[ACC_W-1] ? ACC_W'(-sc_src) : ACC_W'(sc_src);

  always_comb begin
    case (state)
      ST_E_MUL: begin
        mul_a = MUL_W'(w_rdata);
        mul_b = MUL_W'(val_r);
      end
      ST_F_T: begin
        mul_a = $signed({16'd0, tmag});
        mul_b = $signed({16'd0, tmag});
      end
      ST_G_GR: begin
        mul_a = MUL_W'(coef);
        mul_b = MUL_W'(b_val);
      end
      ST_N_MUL: begin
        mul_a = MUL_W'(w_rdata);
        mul_b = MUL_W'(w_rdata);
      end
      ST_SC_HI: begin
        mul_a = $signed({1'b0, reg_weight});
        mul_b = $signed({9'd0, sc_mag[47:24]});
      end
      ST_SC_LO: begin
        mul_a = $signed({1'b0, reg_weight});
        mul_b = $signed({9'd0, sc_mag[23:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // row finish: signed margin and distance to one
  logic signed [48:0] z;
  logic signed [49:0] t;
  logic signed [49:0] hinge_add;

  assign z         = pos_r ? {margin[ACC_W-1], margin} : -{margin[ACC_W-1], margin};
  assign t         = 50'sd65536 - 50'(z);
  assign hinge_add = 50'sd32768 - 50'(z);

  // scale finish
  logic [57:0]              lo;
  logic [49:0]              r_sum;
  logic [48:0]              r_cap;
  logic signed [49:0]       scaled;

  assign lo     = 58'(prod[56:0]) + 58'd32768;
  assign r_sum  = {2'b0, hi_q[39:0], 8'd0} + 50'(lo[57:16]);
  assign r_cap  = ((hi_q >= 57'(1) << 40) || (r_sum > 50'(1) << 48)) ? 49'(1) << 48
                                                                     : r_sum[48:0];
  assign scaled = sc_src[ACC_W-1] ? -$signed({1'b0, r_cap}) : $signed({1'b0, r_cap});

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_WSWEEP;
      cnt           <= '0;
      fill          <= '0;
      margin        <= '0;
      loss          <= '0;
      overflow_seen <= 1'b0;
      reg_weight    <= 32'd65536;
      m_tvalid      <= 1'b0;
    end else begin
      if (reg_weight_we) begin
        reg_weight <= reg_weight_wdata;
      end
      // the output step reloads the register itself
      if (m_tvalid && m_tready && (state != ST_PUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            idx_r  <= in_idx;
            val_r  <= in_val;
            pos_r  <= in_pos;
            last_r <= s_tlast;
            case (in_cmd)
              CMD_SAMPLE_ENTRY: begin
                if (b_we) begin
                  fill  <= fill + 1'b1;
                  state <= ST_E_RD;
                end else begin
                  // full buffer drops the entry but the row end still counts
                  if (in_ok) begin
                    overflow_seen <= 1'b1;
                  end
                  if (s_tlast) begin
                    state <= ST_F_Z;
                  end
                end
              end
              CMD_READ_LOSS: begin
                cnt   <= '0;
                norm  <= '0;
                state <= ST_N_RD;
              end
              CMD_READ_GRAD: begin
                res_kind <= 1'b1;
                if (in_ok) begin
                  state <= ST_R_RD;
                end else begin
                  res   <= '0;
                  state <= ST_PUT;
                end
              end
              CMD_CLEAR: begin
                loss          <= '0;
                overflow_seen <= 1'b0;
                fill          <= '0;
                margin        <= '0;
                cnt           <= '0;
                state         <= ST_GSWEEP;
              end
              default: begin
              end
            endcase
          end
        end

        // zero both memories after reset, gradients only on clear
        ST_WSWEEP, ST_GSWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= ST_IDLE;
          end
        end

        // sample entry: margin += w[i] * x
        ST_E_RD:  state <= ST_E_MUL;
        ST_E_MUL: state <= ST_E_ACC;
        ST_E_ACC: begin
          margin <= sat48(PROD_W'(margin) + rshift16(prod));
          state  <= last_r ? ST_F_Z : ST_IDLE;
        end

        // classify the finished row
        ST_F_Z: begin
          k <= '0;
          if (z >= 49'sd65536) begin
            fill   <= '0;
            margin <= '0;
            state  <= ST_IDLE;
          end else if (z <= 49'sd0) begin
            hinge <= 1'b1;
            loss  <= sat48(PROD_W'(loss) + PROD_W'(hinge_add));
            state <= ST_G_RD;
          end else begin
            hinge <= 1'b0;
            tmag  <= t[16:0];
            coef  <= pos_r ? -$signed({1'b0, t[16:0]}) : $signed({1'b0, t[16:0]});
            state <= ST_F_T;
          end
        end
        ST_F_T:  state <= ST_F_SQ;
        ST_F_SQ: begin
          loss  <= sat48(PROD_W'(loss) + rshift17(prod));
          state <= ST_G_RD;
        end

        // replay the buffered row into the gradient
        ST_G_RD: begin
          if (k == fill) begin
            fill   <= '0;
            margin <= '0;
            state  <= ST_IDLE;
          end else begin
            state <= ST_G_GR;
          end
        end
        ST_G_GR: state <= ST_G_WR;
        ST_G_WR: begin
          k     <= k + 1'b1;
          state <= ST_G_RD;
        end

        // |w|^2 / 2 over all features
        ST_N_RD:  state <= ST_N_MUL;
        ST_N_MUL: state <= ST_N_ACC;
        ST_N_ACC: begin
          norm <= norm + NORM_W'(rshift17(prod));
          if (cnt == CNT_LAST) begin
            sc_src  <= loss;
            sc_loss <= 1'b1;
            state   <= ST_SC_HI;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_N_RD;
          end
        end

        // gradient element read
        ST_R_RD: state <= ST_R_DAT;
        ST_R_DAT: begin
          sc_src  <= g_rdata;
          wsave   <= w_rdata;
          sc_loss <= 1'b0;
          state   <= ST_SC_HI;
        end

        ST_SC_HI: state <= ST_SC_LO;
        ST_SC_LO: begin
          hi_q  <= prod[56:0];
          state <= ST_SC_FIN;
        end
        ST_SC_FIN: begin
          if (sc_loss) begin
            res_kind <= 1'b0;
            if (norm > NORM_W'(ACC_MAX)) begin
              res <= ACC_MAX;
            end else begin
              res <= sat48(PROD_W'(scaled) + PROD_W'({1'b0, norm}));
            end
          end else begin
            res <= sat48(PROD_W'(wsave) + PROD_W'(scaled));
          end
          state <= ST_PUT;
        end

        // output register, waits only if the previous result is still held
        ST_PUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            m_tuser  <= {overflow_seen, res_kind};
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/hsvm_mul.sv
// ----------------------------------------------------------------------------
// hsvm_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module hsvm_mul
  import hsvm_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### verif/huber_svm_loss_gradient_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huber_svm_loss_gradient_unit_tb
// self-checking bench: streams weight writes, sparse sample rows, loss and
// gradient reads and clears into the unit, predicts every objective and
// gradient element in q16.16 and compares each returned transfer with it
// ----------------------------------------------------------------------------
module huber_svm_loss_gradient_unit_tb;
  import hsvm_pkg::*;

  // spare command codes the unit must ignore
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  localparam longint Q_ONE    = 65536;
  localparam longint Q_HALF   = 32768;
  localparam longint MAX_48   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN_48   = -MAX_48 - 1;
  localparam int     SETTLE   = 1100;  // longest silent work: clear sweep or row replay

  typedef struct packed {
    logic [47:0] value;
    logic        kind;
    logic        ovf;
  } svm_result_t;

  // objective / gradient predictor plus the queue of results still owed
  class svm_scoreboard;
    longint      wt[NUM_FEATURES];
    longint      grad[NUM_FEATURES];
    int unsigned row_idx[MAX_ROW];
    longint      row_val[MAX_ROW];
    int          fill;
    longint      margin;
    longint      loss;
    bit          ovf;
    bit [31:0]   c_reg;
    svm_result_t owed[$];
    int          mismatches;

    function new();
      foreach (wt[k]) begin
        wt[k] = 0;
        grad[k] = 0;
      end
      fill = 0;
      margin = 0;
      loss = 0;
      ovf = 0;
      c_reg = 32'd65536;
      mismatches = 0;
    endfunction

    function void set_c(bit [31:0] v);
      c_reg = v;
    endfunction

    function longint clamp48(longint v);
      if (v > MAX_48) return MAX_48;
      if (v < MIN_48) return MIN_48;
      return v;
    endfunction

    // round to nearest, ties away from zero
    function longint round_shr(longint p, int s);
      longint unsigned mag;
      mag = (p < 0) ? longint'(-p) : p;
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return (p < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // multiply by c, magnitude clamped to 2^48
    function longint times_c(longint a);
      longint unsigned mag, ml, mh, hi, lo, r;
      mag = (a < 0) ? longint'(-a) : a;
      ml = mag & 64'hFF_FFFF;
      mh = mag >> 24;
      hi = longint'(c_reg) * mh;
      lo = longint'(c_reg) * ml + 32768;
      if (hi >= (64'd1 << 40)) begin
        r = 64'd1 << 48;
      end else begin
        r = (hi << 8) + (lo >> 16);
        if (r > (64'd1 << 48)) r = 64'd1 << 48;
      end
      return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function void close_row(bit pos);
      longint z, t, add, coef, x, gi;
      bit hinge;
      z = pos ? margin : -margin;
      if (z < Q_ONE) begin
        t = Q_ONE - z;
        hinge = (z <= 0);
        add = hinge ? Q_HALF - z : round_shr(t * t, 17);
        coef = pos ? -t : t;
        loss = clamp48(loss + add);
        for (int k = 0; k < fill; k++) begin
          x = row_val[k];
          gi = hinge ? (pos ? -x : x) : round_shr(coef * x, 16);
          grad[row_idx[k]] = clamp48(grad[row_idx[k]] + gi);
        end
      end
      fill = 0;
      margin = 0;
    endfunction

    // one accepted input transfer
    function void note_input(logic [2:0] cmd, logic [9:0] idx, logic signed [31:0] val,
                             logic pos, logic last);
      svm_result_t r;
      longint unsigned norm;
      longint total;
      case (cmd)
        CMD_WRITE_WEIGHT: wt[idx] = val;
        CMD_SAMPLE_ENTRY: begin
          if (fill < MAX_ROW) begin
            row_idx[fill] = idx;
            row_val[fill] = val;
            fill++;
            margin = clamp48(margin + round_shr(wt[idx] * longint'(val), 16));
          end else begin
            ovf = 1;
          end
          if (last) close_row(pos);
        end
        CMD_READ_LOSS: begin
          norm = 0;
          foreach (wt[k]) norm += round_shr(wt[k] * wt[k], 17);
          total = times_c(loss);
          r.value = 48'((norm > MAX_48) ? MAX_48 : clamp48(total + longint'(norm)));
          r.kind = 0;
          r.ovf = ovf;
          owed = {owed, r};
        end
        CMD_READ_GRAD: begin
          r.value = 48'(clamp48(wt[idx] + times_c(grad[idx])));
          r.kind = 1;
          r.ovf = ovf;
          owed = {owed, r};
        end
        CMD_CLEAR: begin
          foreach (grad[k]) grad[k] = 0;
          loss = 0;
          ovf = 0;
          fill = 0;
          margin = 0;
        end
        default: ;
      endcase
    endfunction

    // one accepted output transfer
    function void check_result(logic [47:0] data, logic [1:0] user);
      svm_result_t e;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h user=%b", data, user);
        return;
      end
      e = owed.pop_front();
      if (data !== e.value || user[0] !== e.kind || user[1] !== e.ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp value=%h kind=%b ovf=%b, got value=%h kind=%b ovf=%b",
                   e.value, e.kind, e.ovf, data, user[0], user[1]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        reg_weight_we;
  logic [31:0] reg_weight_wdata;

  svm_scoreboard sb;
  int  burst_left;
  bit  hold_req;
  int  loss_reads;
  int  items_sent;

  huber_svm_loss_gradient_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .s_tlast          (s_tlast),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .reg_weight_we    (reg_weight_we),
    .reg_weight_wdata (reg_weight_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // offer one transfer and hold it until accepted, then maybe pause
  task automatic send(logic [2:0] cmd, logic [9:0] idx, logic [31:0] val,
                      logic pos, logic last);
    int gap;
    s_tvalid <= 1;
    s_tuser  <= cmd;
    s_tdata  <= {5'b0, pos, val, idx};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, idx, val, pos, last);
    items_sent++;
    if (cmd == CMD_READ_LOSS) loss_reads++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drain all owed results, let silent work finish, then write c
  task automatic write_c(logic [31:0] v);
    s_tvalid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    reg_weight_we    <= 1;
    reg_weight_wdata <= v;
    @(posedge clk);
    sb.set_c(v);
    reg_weight_we <= 0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic logic [9:0] rand_index();
    return ($urandom_range(0, 4) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 31));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // one sample row, mostly short, now and then past the buffer
  task automatic send_row();
    int len;
    logic pos;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    pos = rand_bit();
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 19) == 0)   // weight changes mid-row
        send(CMD_WRITE_WEIGHT, rand_index(), rand_value(), rand_bit(), 1'b0);
      send(CMD_SAMPLE_ENTRY, rand_index(), rand_value(), pos, k == len - 1);
    end
  endtask

  task automatic random_phase(int count);
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_row();
      end else if (pick < 65) begin
        send(CMD_WRITE_WEIGHT, rand_index(), rand_value(), rand_bit(), rand_bit());
      end else if (pick < 90) begin
        send(CMD_READ_GRAD, rand_index(), $urandom(), rand_bit(), rand_bit());
      end else if (pick < 93 && loss_reads < 30) begin
        send(CMD_READ_LOSS, 10'($urandom()), $urandom(), rand_bit(), rand_bit());
      end else if (pick < 94) begin
        send(CMD_CLEAR, 10'($urandom()), $urandom(), rand_bit(), rand_bit());
      end else if (pick < 97) begin
        // broken row: entries with no end mark, at times followed by a clear that throws them away
        send(CMD_SAMPLE_ENTRY, rand_index(), rand_value(), 1'b1, 1'b0);
        send(CMD_SAMPLE_ENTRY, rand_index(), rand_value(), 1'b0, 1'b0);
        if ($urandom_range(0, 3) == 0) send(CMD_CLEAR, 10'd0, 32'd0, 1'b0, 1'b0);
      end else begin
        // noise on the spare codes
        case ($urandom_range(0, 2))
          0:       send(CMD_SPARE_A, 10'($urandom()), $urandom(), 1'b1, 1'b1);
          1:       send(CMD_SPARE_B, 10'($urandom()), $urandom(), 1'b0, 1'b1);
          default: send(CMD_SPARE_C, 10'($urandom()), $urandom(), 1'b1, 1'b0);
        endcase
      end
    end
  endtask

  // receiver: stall pattern of its own plus one long hold-off on request
  initial begin
    int mode;
    int cyc;
    int hold_cnt;
    mode = 0;
    cyc = 0;
    hold_cnt = 0;
    m_tready <= 1;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (hold_req) begin
        hold_cnt = 500;
        hold_req = 0;
      end
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 0;
      end else begin
        case (mode)
          0:       m_tready <= 1;
          1:       m_tready <= rand_bit();
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    sb = new();
    burst_left = 8;
    hold_req = 0;
    loss_reads = 0;
    items_sent = 0;
    rst <= 1;
    s_tvalid <= 0;
    s_tdata <= '0;
    s_tuser <= CMD_WRITE_WEIGHT;
    s_tlast <= 0;
    reg_weight_we <= 0;
    reg_weight_wdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed: extremes, each margin region, mid-row weight change, spare codes
    send(CMD_WRITE_WEIGHT, 10'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send(CMD_WRITE_WEIGHT, 10'd1, 32'h8000_0000, 1'b1, 1'b1);
    send(CMD_WRITE_WEIGHT, 10'd1023, 32'h0001_0000, 1'b0, 1'b0);
    send(CMD_WRITE_WEIGHT, 10'd2, 32'h0001_0000, 1'b0, 1'b0);
    send(CMD_SAMPLE_ENTRY, 10'd2, 32'h0001_0000, 1'b0, 1'b1);   // hinge side
    send(CMD_SAMPLE_ENTRY, 10'd2, 32'h0000_8000, 1'b1, 1'b1);   // quadratic side
    send(CMD_SAMPLE_ENTRY, 10'd2, 32'h0002_0000, 1'b1, 1'b1);   // margin past one
    send(CMD_SAMPLE_ENTRY, 10'd2, 32'h0001_0000, 1'b1, 1'b0);
    send(CMD_WRITE_WEIGHT, 10'd2, 32'hFFFF_0000, 1'b0, 1'b0);
    send(CMD_SAMPLE_ENTRY, 10'd2, 32'h0001_0000, 1'b1, 1'b1);
    send(CMD_SAMPLE_ENTRY, 10'd0, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send(CMD_SAMPLE_ENTRY, 10'd1, 32'h8000_0000, 1'b1, 1'b1);
    send(CMD_SAMPLE_ENTRY, 10'd1023, 32'h8000_0000, 1'b0, 1'b1);
    send(CMD_READ_GRAD, 10'd0, 32'h0, 1'b0, 1'b0);
    send(CMD_READ_GRAD, 10'd1, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send(CMD_READ_GRAD, 10'd2, 32'h0, 1'b0, 1'b0);
    send(CMD_READ_GRAD, 10'd1023, 32'h0, 1'b0, 1'b0);
    send(CMD_READ_LOSS, 10'd0, 32'h0, 1'b0, 1'b0);
    send(CMD_SPARE_A, 10'd3, 32'h1234_5678, 1'b1, 1'b1);
    send(CMD_SPARE_B, 10'd3, 32'h1234_5678, 1'b1, 1'b1);
    send(CMD_SPARE_C, 10'd3, 32'h1234_5678, 1'b1, 1'b1);
    send(CMD_SAMPLE_ENTRY, 10'd3, 32'h0001_0000, 1'b1, 1'b0);
    send(CMD_CLEAR, 10'd0, 32'h0, 1'b0, 1'b0);                  // drops the open row
    send(CMD_READ_LOSS, 10'd0, 32'h0, 1'b0, 1'b0);

    // long receiver hold-off while reads keep coming, so the unit backs up
    hold_req = 1;
    for (int k = 0; k < 12; k++) send(CMD_READ_GRAD, 10'(k), 32'h0, 1'b0, 1'b0);

    // random phases, each under a different c
    write_c(32'd0);
    random_phase(180);
    write_c(32'hFFFF_FFFF);
    random_phase(180);
    write_c(32'd1);
    random_phase(180);
    write_c($urandom());
    random_phase(180);
    write_c(32'h0000_8000);
    random_phase(180);
    write_c(32'd65536);
    random_phase(200);

    s_tvalid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/hsvm_pkg.sv
rtl/core/hsvm_mul.sv
rtl/core/huber_svm_loss_gradient_unit.sv
verif/huber_svm_loss_gradient_unit_tb.sv
